// File: rtl/core/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Result kinds and byte-class constants shared by the decoder and its beats.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    // Kind of a result beat.
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    localparam int unsigned CP_WIDTH  = 31;
    localparam int unsigned REM_WIDTH = 3;

    // Continuation bytes are 10xxxxxx.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_MATCH = 8'h80;
    localparam logic [7:0] PAYLOAD_6  = 8'h3F;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;

    // Sequence lengths; zero marks a byte that cannot open a sequence.
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_ONE = 3'd1;

endpackage : u8sd_pkg

`default_nettype wire

// File: rtl/core/u8sd_stream_if.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : u8sd_in_if

interface u8sd_out_if import u8sd_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [CP_WIDTH-1:0] code_point;
    t_kind               kind;
    logic                string_end;

    modport source (output valid, output code_point, output kind, output string_end,
                    input ready);
    modport sink   (input valid, input code_point, input kind, input string_end,
                    output ready);
endinterface : u8sd_out_if

`default_nettype wire

// File: rtl/core/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes a byte stream in the original UTF-8 form (up to six bytes per
// character) into 31-bit code points, with error and end-of-string reports.
// ----------------------------------------------------------------------------
// Usage: bytes arrive as beats on i_in, one byte per beat, with last_byte set
// on the final byte of each string. Results leave as beats on o_out: a code
// point per completed character, one error beat after a bad byte or an
// unfinished sequence, and an end-only beat when a dropped string finishes.
// Many input beats give no result, since lead and continuation bytes only
// gather bits.
// A taken beat sits in the input register, is decoded there and is written
// to the result register, from which its result leaves on o_out. One byte
// is accepted in every cycle while the output is taken; the decode is a
// single pass of mask tests and a 6-bit shift between the input register
// and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register keeps taking bytes that give no result; a byte that would give a
// result waits there, and i_in.ready drops until the output frees.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to the start of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core
    import u8sd_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    u8sd_in_if.sink        i_in,
    u8sd_out_if.source     o_out
);

    // Input register.
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;

    // Decoder state, carried between bytes of one string.
    logic [CP_WIDTH-1:0]  r_partial,   n_partial;
    logic [REM_WIDTH-1:0] r_remaining, n_remaining;
    logic                 r_discard,   n_discard;

    // Result register.
    logic                 r_out_valid;
    logic [CP_WIDTH-1:0]  r_out_code;
    t_kind                r_out_kind;
    logic                 r_out_end;

    // Decode outcome for the byte in the input register.
    logic                 res_valid;
    logic [CP_WIDTH-1:0]  res_code;
    t_kind                res_kind;

    logic [2:0]           lead_len;
    logic [7:0]           lead_mask;
    logic                 out_free;
    logic                 step;

    // Sequence length from the lead byte's class.
    always_comb begin
        unique casez (r_in_byte)
            8'b0???????: lead_len = LEN_ONE;
            8'b110?????: lead_len = 3'd2;
            8'b1110????: lead_len = 3'd3;
            8'b11110???: lead_len = 3'd4;
            8'b111110??: lead_len = 3'd5;
            8'b1111110?: lead_len = 3'd6;
            default:     lead_len = LEN_BAD;
        endcase
    end

    // Value bits kept from a lead byte of length two or more.
    assign lead_mask = BYTE_ONES >> ({1'b0, lead_len} + 4'd1);

    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_discard   = r_discard;
        res_valid   = 1'b0;
        res_code    = '0;
        res_kind    = KIND_CHAR;

        if (r_discard) begin
            // Dropping the rest of a bad string until its last byte.
            if (r_in_last) begin
                n_discard = 1'b0;
                res_valid = 1'b1;
                res_kind  = KIND_END;
            end
        end else if (r_remaining == '0) begin
            if (lead_len == LEN_BAD) begin
                n_partial = '0;
                n_discard = !r_in_last;
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
            end else if (lead_len == LEN_ONE) begin
                n_partial = '0;
                res_valid = 1'b1;
                res_code  = {{(CP_WIDTH-8){1'b0}}, r_in_byte};
            end else if (r_in_last) begin
                // A multi-byte sequence cannot start on the last byte.
                n_partial = '0;
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
            end else begin
                n_partial   = {{(CP_WIDTH-8){1'b0}}, r_in_byte & lead_mask};
                n_remaining = lead_len - 3'd1;
            end
        end else if ((r_in_byte & CONT_MASK) != CONT_MATCH) begin
            // Expected a continuation byte: drop the partial character.
            n_partial   = '0;
            n_remaining = '0;
            n_discard   = !r_in_last;
            res_valid   = 1'b1;
            res_kind    = KIND_ERROR;
        end else if (r_remaining == 3'd1) begin
            n_partial   = '0;
            n_remaining = '0;
            res_valid   = 1'b1;
            res_code    = {r_partial[CP_WIDTH-7:0], r_in_byte[5:0]};
        end else if (r_in_last) begin
            // String ends in the middle of a sequence.
            n_partial   = '0;
            n_remaining = '0;
            res_valid   = 1'b1;
            res_kind    = KIND_ERROR;
        end else begin
            n_partial   = {r_partial[CP_WIDTH-7:0], r_in_byte[5:0] & PAYLOAD_6[5:0]};
            n_remaining = r_remaining - 3'd1;
        end
    end

    // The byte moves on when it has no result or the result register is free.
    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && (!res_valid || out_free);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_partial   <= '0;
            r_remaining <= '0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_partial   <= n_partial;
                r_remaining <= n_remaining;
                r_discard   <= n_discard;
            end
            if (out_free) begin
                r_out_valid <= step && res_valid;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (out_free && step && res_valid) begin
            r_out_code <= res_code;
            r_out_kind <= res_kind;
            r_out_end  <= r_in_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_code;
    assign o_out.kind       = r_out_kind;
    assign o_out.string_end = r_out_end;

    // While discarding, no sequence may be in progress.
    a_discard_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_remaining == '0))
        else $error("discarding with a sequence in progress");

    // At most five continuation bytes are ever expected.
    a_remaining_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= 3'd5)
        else $error("continuation count out of range");

    // An end-only beat always closes a string.
    a_end_marks_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END) |-> r_out_end)
        else $error("end-only beat without string end");

    // Error and end beats carry no code point.
    a_no_code_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_CHAR) |-> (r_out_code == '0))
        else $error("code point on a non-character beat");

endmodule : utf8_stream_decoder_core

`default_nettype wire

// File: test/tb_utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core testbench
// Feeds byte strings into the decoder and checks every result beat, field by
// field, against an in-bench predictor of the six-byte UTF-8 decode.
// ----------------------------------------------------------------------------
// A short directed part is followed by random strings. Most random strings
// are well formed, with random payload bits; the rest are corrupted strings
// and raw noise. Both sides idle at random. There is a long stretch with no
// idling, one long hold-off of the receiver, and pauses of the sender until
// the decoder has drained.
// ----------------------------------------------------------------------------

module tb_utf8_stream_decoder_core;
    import u8sd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned HOLDOFF_AT    = 400;
    localparam int unsigned HOLDOFF_LEN   = 300;
    localparam int unsigned QUIET_FROM    = 900;
    localparam int unsigned QUIET_TO      = 1200;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct {
        logic [CP_WIDTH-1:0] code_point;
        t_kind               kind;
        logic                string_end;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    u8sd_in_if  byte_ch ();
    u8sd_out_if result_ch ();

    utf8_stream_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_byte_item  pending_bytes[$];
    t_decoded    expected_results[$];
    t_decoded    predicted;
    t_decoded    expected_head;
    int unsigned bytes_accepted = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned rx_hold_cycles;
    bit          holdoff_done;

    // Decoder state as the predictor sees it.
    logic [CP_WIDTH-1:0]  dec_partial   = '0;
    logic [REM_WIDTH-1:0] dec_remaining = '0;
    bit                   dec_dropping  = 1'b0;

    // Neither side idles while this is true.
    function automatic bit in_quiet_stretch();
        return bytes_accepted >= QUIET_FROM && bytes_accepted < QUIET_TO;
    endfunction

    // Any error clears the gathered bits; the rest of the string is dropped
    // unless the error came with the last byte.
    function automatic void flag_error(input logic last, output t_decoded r);
        dec_partial   = '0;
        dec_remaining = '0;
        dec_dropping  = !last;
        r.code_point  = '0;
        r.kind        = KIND_ERROR;
        r.string_end  = last;
    endfunction

    // Works out the result of one byte, if it gives one, and moves the state.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_decoded r);
        logic [2:0] seq_len;
        r.code_point = '0;
        r.kind       = KIND_CHAR;
        r.string_end = last;
        if (dec_dropping) begin
            if (!last)
                return 1'b0;
            dec_dropping = 1'b0;
            r.kind       = KIND_END;
            return 1'b1;
        end
        if (dec_remaining == '0) begin
            casez (b)
                8'b0???????: seq_len = 3'd1;
                8'b110?????: seq_len = 3'd2;
                8'b1110????: seq_len = 3'd3;
                8'b11110???: seq_len = 3'd4;
                8'b111110??: seq_len = 3'd5;
                8'b1111110?: seq_len = 3'd6;
                default:     seq_len = LEN_BAD;
            endcase
            if (seq_len == LEN_BAD) begin
                flag_error(last, r);
                return 1'b1;
            end
            if (seq_len == LEN_ONE) begin
                r.code_point = {{(CP_WIDTH-8){1'b0}}, b};
                return 1'b1;
            end
            dec_partial   = {{(CP_WIDTH-8){1'b0}}, b & (BYTE_ONES >> (seq_len + 3'd1))};
            dec_remaining = seq_len - 3'd1;
            // A lead byte that ends the string leaves the sequence unfinished.
            if (last) begin
                flag_error(1'b1, r);
                return 1'b1;
            end
            return 1'b0;
        end
        if ((b & CONT_MASK) != CONT_MATCH) begin
            flag_error(last, r);
            return 1'b1;
        end
        dec_partial   = {dec_partial[CP_WIDTH-7:0], b[5:0]};
        dec_remaining = dec_remaining - 3'd1;
        if (dec_remaining == '0) begin
            r.code_point = dec_partial;
            dec_partial  = '0;
            return 1'b1;
        end
        if (last) begin
            flag_error(1'b1, r);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver. The queue head is the beat on offer; it is removed once it
    // has been taken, and its prediction is made at that same edge. A beat on
    // offer is never withdrawn, so idling is only decided once the channel is
    // free.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'h00;
            byte_ch.last_byte <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                if (decode_byte(byte_ch.data_byte, byte_ch.last_byte, predicted))
                    expected_results = {expected_results, predicted};
                void'(pending_bytes.pop_front());
                bytes_accepted++;
            end
            if (!(byte_ch.valid && !byte_ch.ready)) begin
                if (pending_bytes.size() != 0 &&
                    (in_quiet_stretch() || $urandom_range(99) >= 10)) begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= pending_bytes[0].data;
                    byte_ch.last_byte <= pending_bytes[0].last;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: once, part way through the random strings, the
    // result side refuses beats for a long stretch while bytes keep coming,
    // so that the decoder has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_cycles <= 0;
            holdoff_done   <= 1'b0;
        end else if (!holdoff_done && bytes_accepted >= HOLDOFF_AT) begin
            rx_hold_cycles <= HOLDOFF_LEN;
            holdoff_done   <= 1'b1;
        end else if (rx_hold_cycles != 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each beat taken is held against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: result beat with none expected: ", $time,
                                 "cp=%h kind=%0d end=%b", result_ch.code_point,
                                 result_ch.kind, result_ch.string_end);
                    error_count++;
                end else begin
                    expected_head = expected_results.pop_front();
                    if (result_ch.code_point !== expected_head.code_point ||
                        result_ch.kind !== expected_head.kind ||
                        result_ch.string_end !== expected_head.string_end) begin
                        if (error_count < REPORT_LIMIT)
                            $display("%0t: mismatch: ", $time,
                                     "expected cp=%h kind=%0d end=%b, ",
                                     expected_head.code_point, expected_head.kind,
                                     expected_head.string_end,
                                     "got cp=%h kind=%0d end=%b",
                                     result_ch.code_point, result_ch.kind,
                                     result_ch.string_end);
                        error_count++;
                    end
                end
            end
            result_ch.ready <= rx_hold_cycles == 0 &&
                               (in_quiet_stretch() || $urandom_range(99) >= 10);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_byte_item item;
        item.data = data;
        item.last = last;
        pending_bytes = {pending_bytes, item};
    endtask

    // Sender pause: nothing more is offered until every expected beat is in.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random strings of roughly the given number of bytes. Most are well
    // formed with random payload; some are corrupted, some are pure noise.
    task automatic push_random_strings(input int unsigned n_bytes);
        logic [7:0]  str[$];
        int unsigned pushed;
        int unsigned mode;
        int unsigned n_chars;
        int unsigned seq_len;
        int unsigned pos;
        logic [7:0]  lead;
        pushed = 0;
        while (pushed < n_bytes) begin
            str.delete();
            mode = $urandom_range(99);
            if (mode < 90) begin
                n_chars = $urandom_range(1, 5);
                repeat (n_chars) begin
                    seq_len = $urandom_range(1, 6);
                    if (seq_len == 1) begin
                        lead = 8'($urandom) & 8'h7F;
                    end else begin
                        lead = (BYTE_ONES << (8 - seq_len)) |
                               (8'($urandom) & (BYTE_ONES >> (seq_len + 1)));
                    end
                    str = {str, lead};
                    repeat (seq_len - 1)
                        str = {str, CONT_MATCH | (8'($urandom) & PAYLOAD_6)};
                end
                // Corrupted strings: a byte overwritten with anything, or the
                // tail cut off so that a sequence may be left open.
                if (mode >= 78) begin
                    pos = $urandom_range(str.size() - 1);
                    if ($urandom_range(1) == 0) begin
                        str[pos] = 8'($urandom);
                    end else begin
                        while (str.size() > pos + 1)
                            void'(str.pop_back());
                    end
                end
            end else begin
                repeat ($urandom_range(1, 8))
                    str = {str, 8'($urandom)};
            end
            foreach (str[i])
                push_byte(str[i], i == str.size() - 1);
            pushed += str.size();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-byte extremes, the smallest two-byte and the largest six-byte
        // code point, and an overlong five-byte zero.
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hC2, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFD, 1'b0);
        repeat (4) push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        push_byte(8'hF8, 1'b0);
        repeat (4) push_byte(8'h80, 1'b0);
        // Bad lead byte mid-string: the rest is dropped up to an end-only beat.
        push_byte(8'hFE, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hFF, 1'b1);
        // Bad lead byte as the last byte.
        push_byte(8'h80, 1'b1);
        // Sequence left unfinished by the last byte.
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b1);
        // Lead byte of a longer form as the last byte.
        push_byte(8'hF0, 1'b1);
        // Bad continuation byte, then the string's end while dropping.
        push_byte(8'hDF, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b1);
        // Bad continuation byte that is the last byte.
        push_byte(8'hC3, 1'b0);
        push_byte(8'hC0, 1'b1);
        wait_drained();

        push_random_strings(820);
        wait_drained();
        push_random_strings(860);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule : tb_utf8_stream_decoder_core
